// ===== hw/rtl/eq_kmc_pkg.sv =====
// types, state codes and helpers of the equalizer key and mode controller
package eq_kmc_pkg;

    // field widths
    localparam int unsigned WAIT_W  = 16;
    localparam int unsigned GAIN_W  = 4;
    localparam int unsigned BAND_W  = 2;
    localparam int unsigned MODE_W  = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NUM_BANDS = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAIN   = 1'd1;

    // reset values and band and gain bounds
    localparam logic [WAIT_W-1:0] WAIT_TICKS_RST = 16'd1000;
    localparam logic [GAIN_W-1:0] MAX_GAIN_RST   = 4'd5;
    localparam logic [BAND_W-1:0] BAND_FIRST     = 2'd1;
    localparam logic [BAND_W-1:0] BAND_LAST      = 2'd3;
    localparam logic [GAIN_W-1:0] GAIN_ONE       = 4'd1;

    // mode codes seen on the result word
    localparam logic [MODE_W-1:0] MODE_IDLE      = 4'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP      = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MUTE      = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SUMEQ     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_WAIT_IDLE = 4'd4;
    localparam logic [MODE_W-1:0] MODE_WAIT_LOOP = 4'd5;
    localparam logic [MODE_W-1:0] MODE_WAIT_MUTE = 4'd6;
    localparam logic [MODE_W-1:0] MODE_WAIT_SUM  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_BAND_UP   = 4'd8;
    localparam logic [MODE_W-1:0] MODE_BAND_DN   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_GAIN_UP   = 4'd10;
    localparam logic [MODE_W-1:0] MODE_GAIN_DN   = 4'd11;

    // controller states, one-hot
    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_LOOP      = 12'b0000_0000_0010,
        S_MUTE      = 12'b0000_0000_0100,
        S_SUMEQ     = 12'b0000_0000_1000,
        S_WAIT_IDLE = 12'b0000_0001_0000,
        S_WAIT_LOOP = 12'b0000_0010_0000,
        S_WAIT_MUTE = 12'b0000_0100_0000,
        S_WAIT_SUM  = 12'b0000_1000_0000,
        S_BAND_UP   = 12'b0001_0000_0000,
        S_BAND_DN   = 12'b0010_0000_0000,
        S_GAIN_UP   = 12'b0100_0000_0000,
        S_GAIN_DN   = 12'b1000_0000_0000
    } t_state;

    // one result word
    typedef struct packed {
        logic [BAND_W-1:0] band_sel;
        logic [GAIN_W-1:0] gain_low;
        logic [GAIN_W-1:0] gain_mid;
        logic [GAIN_W-1:0] gain_high;
        logic [MODE_W-1:0] mode;
        logic              display_update;
    } t_result;

    // state to mode code
    function automatic logic [MODE_W-1:0] state_to_mode(input t_state st);
        logic [MODE_W-1:0] m;
        case (st)
            S_IDLE:      m = MODE_IDLE;
            S_LOOP:      m = MODE_LOOP;
            S_MUTE:      m = MODE_MUTE;
            S_SUMEQ:     m = MODE_SUMEQ;
            S_WAIT_IDLE: m = MODE_WAIT_IDLE;
            S_WAIT_LOOP: m = MODE_WAIT_LOOP;
            S_WAIT_MUTE: m = MODE_WAIT_MUTE;
            S_WAIT_SUM:  m = MODE_WAIT_SUM;
            S_BAND_UP:   m = MODE_BAND_UP;
            S_BAND_DN:   m = MODE_BAND_DN;
            S_GAIN_UP:   m = MODE_GAIN_UP;
            S_GAIN_DN:   m = MODE_GAIN_DN;
            default:     m = MODE_IDLE;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/equalizer_key_mode_controller_top.sv =====
// top level of the equalizer key and mode controller
//
//  channel   direction  handshake               payload
//  in        input      i_in_valid / o_in_stall  six active-low key levels
//  out       output     o_out_valid / i_out_stall band, three gains, mode, display_update
//  cfg       input      i_cfg_valid / o_cfg_ready index, data (wait_ticks, max_gain)
//
// one word per cycle while o_in_stall is low: the state update is one pass of compare,
// increment and wrap logic, and the result is registered in the result register, or in
// the skid register while the result register is held; this two-entry output stage keeps input
// flowing while one result waits; o_in_stall rises only when both are full
// reset is synchronous, active low, and needs no clearing pass
module equalizer_key_mode_controller_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // key words
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_gain_up_key,
    input  logic                                 i_gain_down_key,
    input  logic                                 i_band_up_key,
    input  logic                                 i_band_down_key,
    input  logic                                 i_loop_key,
    input  logic                                 i_mute_key,
    // result words
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [eq_kmc_pkg::BAND_W-1:0]        o_band_sel,
    output logic [eq_kmc_pkg::GAIN_W-1:0]        o_gain_low,
    output logic [eq_kmc_pkg::GAIN_W-1:0]        o_gain_mid,
    output logic [eq_kmc_pkg::GAIN_W-1:0]        o_gain_high,
    output logic [eq_kmc_pkg::MODE_W-1:0]        o_mode,
    output logic                                 o_display_update,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [eq_kmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [eq_kmc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // configuration registers
    logic [eq_kmc_pkg::WAIT_W-1:0] r_wait_ticks;
    logic [eq_kmc_pkg::GAIN_W-1:0] r_max_gain;

    // controller state
    eq_kmc_pkg::t_state            r_state, n_state;
    logic [eq_kmc_pkg::WAIT_W-1:0] r_wait_cnt, n_wait_cnt;
    logic [eq_kmc_pkg::BAND_W-1:0] r_band, n_band;
    logic [eq_kmc_pkg::GAIN_W-1:0] r_gain [eq_kmc_pkg::NUM_BANDS];
    logic [eq_kmc_pkg::GAIN_W-1:0] n_gain [eq_kmc_pkg::NUM_BANDS];

    // output stage
    eq_kmc_pkg::t_result           r_out, r_skid, n_result;
    logic                          r_out_valid, r_skid_valid;

    logic                          accept, taken;
    logic                          k1, k2, k3, k4, k5, k6;
    logic                          disp;
    logic [eq_kmc_pkg::GAIN_W-1:0] eff_max, cur_gain, gain_next;
    logic [eq_kmc_pkg::GAIN_W:0]   gain_inc;
    logic [eq_kmc_pkg::WAIT_W-1:0] wait_inc;
    logic                          wait_done;
    logic [1:0]                    band_idx;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid & ~r_skid_valid;
    assign taken       = r_out_valid & ~i_out_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= eq_kmc_pkg::WAIT_TICKS_RST;
            r_max_gain   <= eq_kmc_pkg::MAX_GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                eq_kmc_pkg::CFG_WAIT_TICKS: r_wait_ticks <= i_cfg_data;
                eq_kmc_pkg::CFG_MAX_GAIN:
                    r_max_gain <= i_cfg_data[eq_kmc_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // key decode, pressed is low
    assign k1 = ~i_gain_up_key;
    assign k2 = ~i_gain_down_key;
    assign k3 = ~i_band_up_key;
    assign k4 = ~i_band_down_key;
    assign k5 = ~i_loop_key;
    assign k6 = ~i_mute_key;

    // gain step helpers for the selected band
    assign eff_max   = (r_max_gain == '0) ? eq_kmc_pkg::GAIN_ONE : r_max_gain;
    assign band_idx  = r_band - 2'd1;
    assign cur_gain  = r_gain[band_idx];
    assign gain_inc  = {1'b0, cur_gain} + 5'd1;
    assign wait_inc  = r_wait_cnt + 16'd1;
    assign wait_done = (wait_inc >= r_wait_ticks);

    // next state for one key word
    always_comb begin
        n_state    = r_state;
        n_wait_cnt = r_wait_cnt;
        n_band     = r_band;
        n_gain     = r_gain;
        disp       = 1'b0;
        gain_next  = cur_gain;
        case (r_state)
            eq_kmc_pkg::S_IDLE: begin
                if (k2)      n_state = eq_kmc_pkg::S_GAIN_DN;
                else if (k4) n_state = eq_kmc_pkg::S_BAND_DN;
                else if (k5) n_state = eq_kmc_pkg::S_WAIT_LOOP;
                else if (k6) n_state = eq_kmc_pkg::S_WAIT_MUTE;
                else if (k1) n_state = eq_kmc_pkg::S_GAIN_UP;
                else if (k3) n_state = eq_kmc_pkg::S_BAND_UP;
            end
            eq_kmc_pkg::S_BAND_UP: begin
                n_band  = (r_band >= eq_kmc_pkg::BAND_LAST) ? eq_kmc_pkg::BAND_FIRST
                                                             : r_band + 2'd1;
                disp    = 1'b1;
                n_state = eq_kmc_pkg::S_WAIT_IDLE;
            end
            eq_kmc_pkg::S_BAND_DN: begin
                n_band  = (r_band <= eq_kmc_pkg::BAND_FIRST) ? eq_kmc_pkg::BAND_LAST
                                                              : r_band - 2'd1;
                disp    = 1'b1;
                n_state = eq_kmc_pkg::S_WAIT_IDLE;
            end
            eq_kmc_pkg::S_GAIN_UP: begin
                gain_next = (gain_inc > {1'b0, eff_max}) ? eq_kmc_pkg::GAIN_ONE
                                                          : gain_inc[eq_kmc_pkg::GAIN_W-1:0];
                n_gain[band_idx] = gain_next;
                disp    = 1'b1;
                n_state = eq_kmc_pkg::S_WAIT_IDLE;
            end
            eq_kmc_pkg::S_GAIN_DN: begin
                gain_next = (cur_gain <= eq_kmc_pkg::GAIN_ONE) ? eff_max
                                                               : cur_gain - 4'd1;
                n_gain[band_idx] = gain_next;
                disp    = 1'b1;
                n_state = eq_kmc_pkg::S_WAIT_IDLE;
            end
            eq_kmc_pkg::S_WAIT_IDLE, eq_kmc_pkg::S_WAIT_LOOP,
            eq_kmc_pkg::S_WAIT_MUTE, eq_kmc_pkg::S_WAIT_SUM: begin
                n_wait_cnt = wait_inc;
                if (wait_done) begin
                    n_wait_cnt = '0;
                    case (r_state)
                        eq_kmc_pkg::S_WAIT_LOOP: n_state = eq_kmc_pkg::S_LOOP;
                        eq_kmc_pkg::S_WAIT_MUTE: n_state = eq_kmc_pkg::S_MUTE;
                        eq_kmc_pkg::S_WAIT_SUM:  n_state = eq_kmc_pkg::S_SUMEQ;
                        default:                 n_state = eq_kmc_pkg::S_IDLE;
                    endcase
                end
            end
            eq_kmc_pkg::S_LOOP: begin
                if (k5)      n_state = eq_kmc_pkg::S_WAIT_IDLE;
                else if (k6) n_state = eq_kmc_pkg::S_WAIT_MUTE;
                else if (k1) n_state = eq_kmc_pkg::S_WAIT_SUM;
            end
            eq_kmc_pkg::S_MUTE, eq_kmc_pkg::S_SUMEQ: begin
                if (k5) n_state = eq_kmc_pkg::S_WAIT_IDLE;
            end
            default: n_state = eq_kmc_pkg::S_IDLE;
        endcase
    end

    // result word after this key word
    always_comb begin
        n_result.band_sel       = n_band;
        n_result.gain_low       = n_gain[0];
        n_result.gain_mid       = n_gain[1];
        n_result.gain_high      = n_gain[2];
        n_result.mode           = eq_kmc_pkg::state_to_mode(n_state);
        n_result.display_update = disp;
    end

    // controller state update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= eq_kmc_pkg::S_IDLE;
            r_wait_cnt <= '0;
            r_band     <= eq_kmc_pkg::BAND_FIRST;
            r_gain[0]  <= eq_kmc_pkg::GAIN_ONE;
            r_gain[1]  <= eq_kmc_pkg::GAIN_ONE;
            r_gain[2]  <= eq_kmc_pkg::GAIN_ONE;
        end else if (accept) begin
            r_state    <= n_state;
            r_wait_cnt <= n_wait_cnt;
            r_band     <= n_band;
            r_gain     <= n_gain;
        end
    end

    // output register with skid entry, control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || taken) begin
            r_out_valid  <= r_skid_valid | accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output register with skid entry, payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || taken) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    // result ports
    assign o_out_valid      = r_out_valid;
    assign o_band_sel       = r_out.band_sel;
    assign o_gain_low       = r_out.gain_low;
    assign o_gain_mid       = r_out.gain_mid;
    assign o_gain_high      = r_out.gain_high;
    assign o_mode           = r_out.mode;
    assign o_display_update = r_out.display_update;

endmodule
